FILE: sv/button_bellows_midi_note_mapper_assert.svh
// ---------------------------------------------------------------------------
// button box note mapper assertion macros
// shared concurrent assertion forms for the checker
// ---------------------------------------------------------------------------
`ifndef BUTTON_BELLOWS_MIDI_NOTE_MAPPER_ASSERT_SVH
`define BUTTON_BELLOWS_MIDI_NOTE_MAPPER_ASSERT_SVH

// property checked only outside reset
`define BBNM_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("bbnm assertion failed");

// property checked on every edge, reset included
`define BBNM_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("bbnm assertion failed");

`endif

FILE: sv/bbnm_pkg.sv
// ---------------------------------------------------------------------------
// bbnm_pkg
// shared widths, codes and note tables of the button box note mapper
// ---------------------------------------------------------------------------
`default_nettype none

package bbnm_pkg;

   localparam int NUM_BUTTONS = 12;

   // field widths
   localparam int KIND_W   = 3;
   localparam int BUTTON_W = 4;
   localparam int ROW_W    = 4;
   localparam int NOTE_W   = 7;
   localparam int MSG_W    = 2;
   localparam int KEY_W    = 3;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 7;

   // input event kinds
   localparam logic [KIND_W-1:0] KIND_DOWN    = 3'd0;
   localparam logic [KIND_W-1:0] KIND_UP      = 3'd1;
   localparam logic [KIND_W-1:0] KIND_PUSH    = 3'd2;
   localparam logic [KIND_W-1:0] KIND_RELEASE = 3'd3;
   localparam logic [KIND_W-1:0] KIND_LOST    = 3'd4;
   localparam logic [KIND_W-1:0] KIND_SELECT  = 3'd5;

   // result message kinds
   localparam logic [MSG_W-1:0] MSG_NOTE_ON  = 2'd0;
   localparam logic [MSG_W-1:0] MSG_NOTE_OFF = 2'd1;
   localparam logic [MSG_W-1:0] MSG_ALL_OFF  = 2'd2;
   localparam logic [MSG_W-1:0] MSG_PROGRAM  = 2'd3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_REVERSE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_VOLUME  = 2'd2;

   // register reset values
   localparam logic [KEY_W-1:0]  KEY_RESET    = 3'd3;
   localparam logic [NOTE_W-1:0] VOLUME_RESET = 7'd127;

   // note of a row, pull column (push = 0) or push column (push = 1)
   function automatic logic [NOTE_W-1:0] note_of(input logic [ROW_W-1:0] row,
                                                 input logic push);
      logic [NOTE_W-1:0] pull_note;
      logic [NOTE_W-1:0] push_note;
      case (row)
         4'd0:    begin pull_note = 7'd48; push_note = 7'd53; end
         4'd1:    begin pull_note = 7'd52; push_note = 7'd57; end
         4'd2:    begin pull_note = 7'd55; push_note = 7'd59; end
         4'd3:    begin pull_note = 7'd60; push_note = 7'd62; end
         4'd4:    begin pull_note = 7'd64; push_note = 7'd65; end
         4'd5:    begin pull_note = 7'd67; push_note = 7'd69; end
         4'd6:    begin pull_note = 7'd72; push_note = 7'd71; end
         4'd7:    begin pull_note = 7'd76; push_note = 7'd74; end
         4'd8:    begin pull_note = 7'd79; push_note = 7'd77; end
         4'd9:    begin pull_note = 7'd84; push_note = 7'd81; end
         4'd10:   begin pull_note = 7'd88; push_note = 7'd83; end
         4'd11:   begin pull_note = 7'd91; push_note = 7'd86; end
         default: begin pull_note = 7'd0;  push_note = 7'd0;  end
      endcase
      return push ? push_note : pull_note;
   endfunction

   // transposition of a key, unused code transposes by zero
   function automatic logic signed [3:0] key_offset(input logic [KEY_W-1:0] key);
      case (key)
         3'd0:    return 4'sd3;
         3'd1:    return -4'sd2;
         3'd2:    return 4'sd5;
         3'd3:    return 4'sd0;
         3'd4:    return -4'sd5;
         3'd5:    return 4'sd2;
         3'd6:    return -4'sd3;
         default: return 4'sd0;
      endcase
   endfunction

endpackage

`default_nettype wire

FILE: sv/bbnm_req_if.sv
// ---------------------------------------------------------------------------
// bbnm_req_if
// input event channel: valid, ready and the event payload
// ---------------------------------------------------------------------------
`default_nettype none

interface bbnm_req_if import bbnm_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [KIND_W-1:0]    kind;
   logic [BUTTON_W-1:0]  button;
   logic [NOTE_W-1:0]    program_req;

   modport source (output valid, kind, button, program_req, input ready);
   modport sink   (input valid, kind, button, program_req, output ready);
endinterface

`default_nettype wire

FILE: sv/bbnm_rsp_if.sv
// ---------------------------------------------------------------------------
// bbnm_rsp_if
// result message channel: valid, ready and the message payload
// ---------------------------------------------------------------------------
`default_nettype none

interface bbnm_rsp_if import bbnm_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [MSG_W-1:0]   msg_kind;
   logic [NOTE_W-1:0]  note;
   logic [NOTE_W-1:0]  velocity;
   logic               last;

   modport source (output valid, msg_kind, note, velocity, last, input ready);
   modport sink   (input valid, msg_kind, note, velocity, last, output ready);
endinterface

`default_nettype wire

FILE: sv/bbnm_pitch.sv
// ---------------------------------------------------------------------------
// bbnm_pitch
// shared pitch unit: table lookup by row and bellows, plus key transposition
// ---------------------------------------------------------------------------
`default_nettype none

module bbnm_pitch import bbnm_pkg::*; (
   input  wire logic [ROW_W-1:0]  row,
   input  wire logic              pushed,
   input  wire logic [KEY_W-1:0]  key,
   output logic      [NOTE_W-1:0] note
);

   logic signed [NOTE_W:0] base;
   logic signed [NOTE_W:0] sum;

   // table note plus signed key offset, kept to seven bits
   assign base = signed'({1'b0, note_of(row, pushed)});
   assign sum  = base + (NOTE_W+1)'(key_offset(key));
   assign note = sum[NOTE_W-1:0];

endmodule

`default_nettype wire

FILE: sv/button_bellows_midi_note_mapper.sv
// ---------------------------------------------------------------------------
// button_bellows_midi_note_mapper
// button and bellows events of a button box in, note messages out
// ---------------------------------------------------------------------------
// One event is taken at a time; req.ready is high only while the sequencer is
// idle, and a finished message may still wait in the output register then.
// A button event passes through ST_NOTE (transfer, then one message), a program
// select through ST_PROG, focus lost through ST_ALLOFF. A bellows change emits
// all-notes-off and then walks the held-button mask one row per cycle through
// the shared pitch unit, pausing on a held row while the output is stalled.
// Repeated presses, releases of free buttons, unchanged bellows, buttons out
// of range and unused kinds produce no message and leave the block idle. The
// user must write registers through csr_we, csr_index and csr_wdata only while
// no event is in progress; the block itself does not enforce this.
`default_nettype none

module button_bellows_midi_note_mapper import bbnm_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   bbnm_req_if.sink                   req,
   bbnm_rsp_if.source                 rsp,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_NOTE,
      ST_ALLOFF,
      ST_PROG,
      ST_SCAN
   } state_type;

   state_type               state_ff,     state_in;
   logic [NUM_BUTTONS-1:0]  held_ff,      held_in;
   logic                    pushed_ff,    pushed_in;
   logic [NUM_BUTTONS-1:0]  mask_ff,      mask_in;
   logic [ROW_W-1:0]        row_ff,       row_in;
   logic [MSG_W-1:0]        msg_ff,       msg_in;
   logic [NOTE_W-1:0]       prog_ff,      prog_in;
   logic                    reverse_ff,   reverse_in;
   logic [KEY_W-1:0]        key_ff,       key_in;
   logic [NOTE_W-1:0]       volume_ff,    volume_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [MSG_W-1:0]        rsp_kind_ff,  rsp_kind_in;
   logic [NOTE_W-1:0]       rsp_note_ff,  rsp_note_in;
   logic [NOTE_W-1:0]       rsp_vel_ff,   rsp_vel_in;
   logic                    rsp_last_ff,  rsp_last_in;

   logic                    slot_free;
   logic [ROW_W-1:0]        req_row;
   logic [NUM_BUTTONS-1:0]  mask_clr;
   logic [NOTE_W-1:0]       pitch;

   // shared pitch unit, always looks at the current row
   bbnm_pitch u_pitch (
      .row    (row_ff),
      .pushed (pushed_ff),
      .key    (key_ff),
      .note   (pitch)
   );

   assign req.ready    = (state_ff == ST_IDLE);
   assign rsp.valid    = rsp_valid_ff;
   assign rsp.msg_kind = rsp_kind_ff;
   assign rsp.note     = rsp_note_ff;
   assign rsp.velocity = rsp_vel_ff;
   assign rsp.last     = rsp_last_ff;

   assign slot_free = !rsp_valid_ff || rsp.ready;
   assign req_row   = reverse_ff ? req.button
                                 : ROW_W'(NUM_BUTTONS - 1) - req.button;
   assign mask_clr  = mask_ff & ~(NUM_BUTTONS'(1) << row_ff);

   // sequencer and configuration next state
   always_comb begin
      state_in     = state_ff;
      held_in      = held_ff;
      pushed_in    = pushed_ff;
      mask_in      = mask_ff;
      row_in       = row_ff;
      msg_in       = msg_ff;
      prog_in      = prog_ff;
      reverse_in   = reverse_ff;
      key_in       = key_ff;
      volume_in    = volume_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_note_in  = rsp_note_ff;
      rsp_vel_in   = rsp_vel_ff;
      rsp_last_in  = rsp_last_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req.valid) begin
               case (req.kind)
                  KIND_DOWN, KIND_UP: begin
                     if (req.button < BUTTON_W'(NUM_BUTTONS)) begin
                        row_in = req_row;
                        if (req.kind == KIND_DOWN && !held_ff[req_row]) begin
                           held_in[req_row] = 1'b1;
                           msg_in           = MSG_NOTE_ON;
                           state_in         = ST_NOTE;
                        end else if (req.kind == KIND_UP && held_ff[req_row]) begin
                           held_in[req_row] = 1'b0;
                           msg_in           = MSG_NOTE_OFF;
                           state_in         = ST_NOTE;
                        end
                     end
                  end
                  KIND_PUSH, KIND_RELEASE: begin
                     if (pushed_ff != (req.kind == KIND_PUSH)) begin
                        pushed_in = (req.kind == KIND_PUSH);
                        mask_in   = held_ff;
                        row_in    = '0;
                        state_in  = ST_ALLOFF;
                     end
                  end
                  KIND_LOST: begin
                     held_in  = '0;
                     mask_in  = '0;
                     state_in = ST_ALLOFF;
                  end
                  KIND_SELECT: begin
                     prog_in  = req.program_req;
                     state_in = ST_PROG;
                  end
                  default: begin
                  end
               endcase
            end
         end
         // single note on or note off
         ST_NOTE: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = msg_ff;
               rsp_note_in  = pitch;
               rsp_vel_in   = volume_ff;
               rsp_last_in  = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         // all notes off, last when nothing follows
         ST_ALLOFF: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = MSG_ALL_OFF;
               rsp_note_in  = '0;
               rsp_vel_in   = '0;
               rsp_last_in  = (mask_ff == '0);
               state_in     = (mask_ff == '0) ? ST_IDLE : ST_SCAN;
            end
         end
         ST_PROG: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = MSG_PROGRAM;
               rsp_note_in  = prog_ff;
               rsp_vel_in   = '0;
               rsp_last_in  = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         // walk held rows in ascending order, one row per cycle unless the output stalls
         ST_SCAN: begin
            if (mask_ff[row_ff]) begin
               if (slot_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_kind_in  = MSG_NOTE_ON;
                  rsp_note_in  = pitch;
                  rsp_vel_in   = volume_ff;
                  rsp_last_in  = (mask_clr == '0);
                  mask_in      = mask_clr;
                  row_in       = row_ff + 1'b1;
                  if (mask_clr == '0) begin
                     state_in = ST_IDLE;
                  end
               end
            end else begin
               row_in = row_ff + 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // register writes
      if (csr_we) begin
         case (csr_index)
            CSR_REVERSE: reverse_in = csr_wdata[0];
            CSR_KEY:     key_in     = csr_wdata[KEY_W-1:0];
            CSR_VOLUME:  volume_in  = csr_wdata[NOTE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // state, configuration and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         held_ff      <= '0;
         pushed_ff    <= 1'b0;
         reverse_ff   <= 1'b0;
         key_ff       <= KEY_RESET;
         volume_ff    <= VOLUME_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         held_ff      <= held_in;
         pushed_ff    <= pushed_in;
         reverse_ff   <= reverse_in;
         key_ff       <= key_in;
         volume_ff    <= volume_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mask_ff     <= mask_in;
      row_ff      <= row_in;
      msg_ff      <= msg_in;
      prog_ff     <= prog_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_note_ff <= rsp_note_in;
      rsp_vel_ff  <= rsp_vel_in;
      rsp_last_ff <= rsp_last_in;
   end

endmodule

`default_nettype wire

FILE: sv/bbnm_checker.sv
// ---------------------------------------------------------------------------
// bbnm_checker
// port-level checks of the button box note mapper, bound to the top level
// ---------------------------------------------------------------------------
`default_nettype none

`include "button_bellows_midi_note_mapper_assert.svh"

module bbnm_checker import bbnm_pkg::*; (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_valid,
   input wire logic               req_ready,
   input wire logic [KIND_W-1:0]  req_kind,
   input wire logic               rsp_valid,
   input wire logic               rsp_ready,
   input wire logic [MSG_W-1:0]   rsp_msg_kind,
   input wire logic [NOTE_W-1:0]  rsp_note,
   input wire logic [NOTE_W-1:0]  rsp_velocity,
   input wire logic               rsp_last
);

   logic [MSG_W+2*NOTE_W:0] rsp_payload;
   logic                    rsp_stall;
   logic                    req_xfer;
   logic                    no_velocity_kind;

   // handshake and payload shorthands
   assign rsp_payload      = {rsp_msg_kind, rsp_note, rsp_velocity, rsp_last};
   assign rsp_stall        = rsp_valid && !rsp_ready;
   assign req_xfer         = req_valid && req_ready;
   assign no_velocity_kind = (rsp_msg_kind == MSG_ALL_OFF) || (rsp_msg_kind == MSG_PROGRAM);

   // a stalled message holds its payload
   `BBNM_ASSERT(a_rsp_hold, clock, reset, rsp_stall |=> rsp_valid && $stable(rsp_payload))

   // nothing is offered right after reset
   `BBNM_ASSERT_ALWAYS(a_reset_quiet, clock, reset |=> !rsp_valid)

   // a program select always keeps the sequencer busy for its message
   `BBNM_ASSERT(a_select_busy, clock, reset, req_xfer && req_kind == KIND_SELECT |=> !req_ready)

   // unused kinds leave the block ready
   `BBNM_ASSERT(a_unused_idle, clock, reset, req_xfer && req_kind > KIND_SELECT |=> req_ready)

   // all notes off and program change carry no velocity
   `BBNM_ASSERT(a_no_velocity, clock, reset, rsp_valid && no_velocity_kind |-> rsp_velocity == '0)

endmodule

bind button_bellows_midi_note_mapper bbnm_checker u_bbnm_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req.valid),
   .req_ready    (req.ready),
   .req_kind     (req.kind),
   .rsp_valid    (rsp.valid),
   .rsp_ready    (rsp.ready),
   .rsp_msg_kind (rsp.msg_kind),
   .rsp_note     (rsp.note),
   .rsp_velocity (rsp.velocity),
   .rsp_last     (rsp.last)
);

`default_nettype wire

FILE: test/button_bellows_midi_note_mapper_test.sv
// ---------------------------------------------------------------------------
// button_bellows_midi_note_mapper_test
// self-checking bench: button, bellows, focus and instrument events go in
// with random gaps, every note message coming out is compared field by field
// with a prediction kept in a small scoreboard, over several register settings
// ---------------------------------------------------------------------------
module button_bellows_midi_note_mapper_test import bbnm_pkg::*;;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int DRAIN_CYCLES = 24;

   // one note message as it leaves the block
   typedef struct packed {
      logic [MSG_W-1:0]  msg_kind;
      logic [NOTE_W-1:0] note;
      logic [NOTE_W-1:0] velocity;
      logic              last;
   } midi_msg_type;

   // predicted button box state and the queue of messages still owed
   class note_scoreboard;
      int pull_note [NUM_BUTTONS] = '{48, 52, 55, 60, 64, 67, 72, 76, 79, 84, 88, 91};
      int push_note [NUM_BUTTONS] = '{53, 57, 59, 62, 65, 69, 71, 74, 77, 81, 83, 86};
      int key_shift [8]           = '{3, -2, 5, 0, -5, 2, -3, 0};

      bit                held [NUM_BUTTONS];
      bit                pushed;
      bit                reverse;
      logic [KEY_W-1:0]  key;
      logic [NOTE_W-1:0] volume;
      midi_msg_type      owed_q [$];
      int                errors;
      int                events;
      int                messages;
      int                most_per_event;

      function new();
         foreach (held[r]) held[r] = 1'b0;
         pushed         = 1'b0;
         reverse        = 1'b0;
         key            = KEY_RESET;
         volume         = VOLUME_RESET;
         errors         = 0;
         events         = 0;
         messages       = 0;
         most_per_event = 0;
      endfunction

      function void set_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
         case (idx)
            CSR_REVERSE: reverse = value[0];
            CSR_KEY:     key     = value[KEY_W-1:0];
            CSR_VOLUME:  volume  = value;
            default: ;
         endcase
      endfunction

      function int row_of(logic [BUTTON_W-1:0] button);
         return reverse ? int'(button) : NUM_BUTTONS - 1 - int'(button);
      endfunction

      function logic [NOTE_W-1:0] pitch(int row);
         int v;
         v = (pushed ? push_note[row] : pull_note[row]) + key_shift[key];
         return v[NOTE_W-1:0];
      endfunction

      function midi_msg_type message(logic [MSG_W-1:0] kind, logic [NOTE_W-1:0] note,
                                     logic [NOTE_W-1:0] velocity);
         midi_msg_type m;
         m.msg_kind = kind;
         m.note     = note;
         m.velocity = velocity;
         m.last     = 1'b0;
         return m;
      endfunction

      // one accepted event: update the state and queue the messages it owes
      function void note_event(logic [KIND_W-1:0] kind, logic [BUTTON_W-1:0] button,
                               logic [NOTE_W-1:0] prog);
         midi_msg_type burst [$];
         int           row;
         events++;
         case (kind)
            KIND_DOWN, KIND_UP: begin
               if (button < NUM_BUTTONS) begin
                  row = row_of(button);
                  if (kind == KIND_DOWN && !held[row]) begin
                     held[row] = 1'b1;
                     burst.push_back(message(MSG_NOTE_ON, pitch(row), volume));
                  end else if (kind == KIND_UP && held[row]) begin
                     held[row] = 1'b0;
                     burst.push_back(message(MSG_NOTE_OFF, pitch(row), volume));
                  end
               end
            end
            KIND_PUSH, KIND_RELEASE: begin
               if (pushed != (kind == KIND_PUSH)) begin
                  pushed = (kind == KIND_PUSH);
                  burst.push_back(message(MSG_ALL_OFF, '0, '0));
                  for (int r = 0; r < NUM_BUTTONS; r++)
                     if (held[r]) burst.push_back(message(MSG_NOTE_ON, pitch(r), volume));
               end
            end
            KIND_LOST: begin
               foreach (held[r]) held[r] = 1'b0;
               burst.push_back(message(MSG_ALL_OFF, '0, '0));
            end
            KIND_SELECT: burst.push_back(message(MSG_PROGRAM, prog, '0));
            default: ;
         endcase
         if (burst.size() > 0) burst[burst.size() - 1].last = 1'b1;
         if (burst.size() > most_per_event) most_per_event = burst.size();
         foreach (burst[i]) owed_q.push_back(burst[i]);
      endfunction

      // one accepted message against the oldest one owed
      function void check_message(midi_msg_type got);
         midi_msg_type want;
         messages++;
         if (owed_q.size() == 0) begin
            $error("unexpected message: msg_kind %0d note %0d velocity %0d last %0d",
                   got.msg_kind, got.note, got.velocity, got.last);
            errors++;
            return;
         end
         want = owed_q.pop_front();
         if (got.msg_kind !== want.msg_kind) begin
            $error("msg_kind: expected %0d, got %0d", want.msg_kind, got.msg_kind);
            errors++;
         end
         if (got.note !== want.note) begin
            $error("note: expected %0d, got %0d", want.note, got.note);
            errors++;
         end
         if (got.velocity !== want.velocity) begin
            $error("velocity: expected %0d, got %0d", want.velocity, got.velocity);
            errors++;
         end
         if (got.last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, got.last);
            errors++;
         end
      endfunction

      function int pending();
         return owed_q.size();
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   bbnm_req_if req_bus ();
   bbnm_rsp_if rsp_bus ();

   note_scoreboard sb = new();

   bit calm;          // no idling on either side
   bit squeeze_req;   // ask the receiver for one long hold-off
   int settings_used;

   button_bellows_midi_note_mapper DUT (
      .clock     (clock),
      .reset     (reset),
      .req       (req_bus),
      .rsp       (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #3ms;
      $display("== FAIL ==");
      $finish;
   end

   // offer one event and hold it until the transfer; starts and ends at a clock edge
   task automatic send_event(input logic [KIND_W-1:0] kind, input logic [BUTTON_W-1:0] button,
                             input logic [NOTE_W-1:0] prog);
      int gap;
      gap = (!calm && $urandom_range(0, 9) < 4) ? $urandom_range(1, 13) : 0;
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.kind        <= kind;
      req_bus.button      <= button;
      req_bus.program_req <= prog;
      do @(posedge clock); while (!req_bus.ready);
      sb.note_event(kind, button, prog);
   endtask

   // drop valid and let every owed message and any silent event finish
   task automatic drain();
      req_bus.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // write all three registers while the block is idle
   task automatic write_settings(input bit rev, input int key, input int vol);
      logic [CSR_IDX_W-1:0]  idx  [3];
      logic [CSR_DATA_W-1:0] data [3];
      idx[0] = CSR_REVERSE; data[0] = CSR_DATA_W'(rev);
      idx[1] = CSR_KEY;     data[1] = CSR_DATA_W'(key);
      idx[2] = CSR_VOLUME;  data[2] = CSR_DATA_W'(vol);
      for (int i = 0; i < 3; i++) begin
         csr_we    <= 1'b1;
         csr_index <= idx[i];
         csr_wdata <= data[i];
         @(posedge clock);
         sb.set_register(idx[i], data[i]);
      end
      csr_we <= 1'b0;
      settings_used++;
   endtask

   // press every button, then turn the bellows: the longest burst of messages
   task automatic play_chord(inout int count);
      int first;
      first = $urandom_range(0, NUM_BUTTONS - 1);
      for (int i = 0; i < NUM_BUTTONS; i++)
         send_event(KIND_DOWN, BUTTON_W'((first + i) % NUM_BUTTONS), NOTE_W'($urandom));
      send_event(sb.pushed ? KIND_RELEASE : KIND_PUSH, BUTTON_W'($urandom), NOTE_W'($urandom));
      count += NUM_BUTTONS + 1;
   endtask

   // one random event, mostly playing, some noise
   task automatic send_random(inout int count);
      int                  pick;
      logic [BUTTON_W-1:0] b;
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
         play_chord(count);
      end else if (pick < 36) begin
         send_event(KIND_DOWN, BUTTON_W'($urandom_range(0, NUM_BUTTONS - 1)), NOTE_W'($urandom));
         count++;
      end else if (pick < 58) begin
         // prefer a button that is held
         b = BUTTON_W'($urandom_range(0, NUM_BUTTONS - 1));
         for (int t = 0; t < NUM_BUTTONS && !sb.held[sb.row_of(b)]; t++)
            b = BUTTON_W'($urandom_range(0, NUM_BUTTONS - 1));
         send_event(KIND_UP, b, NOTE_W'($urandom));
         count++;
      end else if (pick < 74) begin
         if ($urandom_range(0, 9) < 8)
            send_event(sb.pushed ? KIND_RELEASE : KIND_PUSH, BUTTON_W'($urandom),
                       NOTE_W'($urandom));
         else
            send_event(sb.pushed ? KIND_PUSH : KIND_RELEASE, BUTTON_W'($urandom),
                       NOTE_W'($urandom));
         count++;
      end else if (pick < 80) begin
         send_event(KIND_LOST, BUTTON_W'($urandom), NOTE_W'($urandom));
         count++;
      end else if (pick < 90) begin
         send_event(KIND_SELECT, BUTTON_W'($urandom), NOTE_W'($urandom_range(0, 127)));
         count++;
      end else if (pick < 95) begin
         // button past the end of the row, ignored
         send_event($urandom_range(0, 1) ? KIND_DOWN : KIND_UP,
                    BUTTON_W'($urandom_range(NUM_BUTTONS, 15)), NOTE_W'($urandom));
      end else begin
         send_event(KIND_W'($urandom_range(6, 7)), BUTTON_W'($urandom), NOTE_W'($urandom));
      end
   endtask

   // event source: reset, directed events, then random phases
   initial begin
      int rev_of [7];
      int key_of [7];
      int vol_of [7];
      int count;
      int guard;

      rev_of = '{1, 0, 1, 0, 1, 0, 1};
      key_of = '{0, 6, 7, 4, 5, 2, 1};
      vol_of = '{0, 127, $urandom_range(1, 126), $urandom_range(0, 127), 1, 127,
                 $urandom_range(0, 127)};
      reset               <= 1'b1;
      csr_we              <= 1'b0;
      csr_index           <= '0;
      csr_wdata           <= '0;
      req_bus.valid       <= 1'b0;
      req_bus.kind        <= '0;
      req_bus.button      <= '0;
      req_bus.program_req <= '0;
      calm          = 1'b0;
      squeeze_req   = 1'b0;
      settings_used = 1;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed events at the reset settings
      send_event(KIND_SELECT, 4'd0, 7'd0);
      send_event(KIND_SELECT, 4'd15, 7'd127);
      send_event(KIND_DOWN, 4'd0, 7'd0);
      send_event(KIND_DOWN, 4'd11, 7'd0);
      send_event(KIND_DOWN, 4'd0, 7'd0);         // repeated press
      send_event(KIND_UP, 4'd5, 7'd0);           // release of a free button
      send_event(KIND_PUSH, 4'd0, 7'd0);         // bellows change with two held
      send_event(KIND_PUSH, 4'd0, 7'd0);         // bellows unchanged
      send_event(KIND_DOWN, 4'd15, 7'd0);        // out of range
      send_event(KIND_UP, 4'd12, 7'd0);
      send_event(3'd6, 4'd3, 7'd1);              // unused kinds
      send_event(3'd7, 4'd3, 7'd1);
      send_event(KIND_RELEASE, 4'd0, 7'd0);
      send_event(KIND_RELEASE, 4'd0, 7'd0);
      send_event(KIND_UP, 4'd0, 7'd0);
      send_event(KIND_LOST, 4'd0, 7'd0);
      send_event(KIND_UP, 4'd11, 7'd0);          // cleared by focus lost
      send_event(KIND_PUSH, 4'd0, 7'd0);         // bellows change with none held
      send_event(KIND_LOST, 4'd0, 7'd0);         // bellows kept pushed
      send_event(KIND_DOWN, 4'd8, 7'd0);
      send_event(KIND_RELEASE, 4'd0, 7'd0);
      send_event(KIND_UP, 4'd8, 7'd0);
      drain();

      // random phases, one register setting each, last one without idling
      for (int p = 0; p < 7; p++) begin
         write_settings(rev_of[p][0], key_of[p], vol_of[p]);
         calm  = (p == 6);
         count = 0;
         if (p == 0) begin
            squeeze_req = 1'b1;
            play_chord(count);
         end
         while (count < 22) send_random(count);
         drain();
      end

      guard = 0;
      while (sb.pending() != 0 && guard < 20000) begin
         @(posedge clock);
         guard++;
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d events and %0d messages, up to %0d messages from one event",
               sb.events, sb.messages, sb.most_per_event);
      $display("over %0d register settings: both button orders, every key, volume extremes",
               settings_used);
      if (sb.pending() != 0) $error("%0d expected messages never arrived", sb.pending());
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // message sink: random stalls, one long hold-off, checks each transfer
   initial begin
      int stall_left;
      int run_left;
      bit squeezed;
      midi_msg_type got;

      stall_left = 0;
      run_left   = 0;
      squeezed   = 1'b0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.msg_kind = rsp_bus.msg_kind;
            got.note     = rsp_bus.note;
            got.velocity = rsp_bus.velocity;
            got.last     = rsp_bus.last;
            sb.check_message(got);
         end
         if (squeeze_req && !squeezed) begin
            squeezed   = 1'b1;
            stall_left = 90;
            run_left   = 0;
         end else if (calm) begin
            stall_left = 0;
         end else if (stall_left == 0 && run_left == 0) begin
            if ($urandom_range(0, 2) == 0) stall_left = $urandom_range(1, 13);
            else run_left = $urandom_range(1, 40);
         end
         if (stall_left > 0) begin
            rsp_bus.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_bus.ready <= 1'b1;
            if (run_left > 0) run_left--;
         end
      end
   end

endmodule
